>>> rtl/core/dce_pkg.sv
`timescale 1ns / 1ps

package dce_pkg;

	// Completion pulse length in ticks and the width of its counter.
	localparam int unsigned IRQ_PULSE_TICKS = 100000;
	localparam int unsigned PULSE_W = 17;

	// Register window offsets relative to the base address.
	localparam logic [31:0] OFF_SOURCE = 32'd0;
	localparam logic [31:0] OFF_TARGET = 32'd4;
	localparam logic [31:0] OFF_COUNT = 32'd8;
	localparam logic [31:0] OFF_START = 32'd12;

	// Address step and full word length of one transfer.
	localparam logic [31:0] WORD_STEP = 32'd4;
	localparam logic [2:0] WORD_BYTES = 3'd4;

	// Input commands.
	typedef enum logic [1:0] {
		CMD_REG_WRITE = 2'd0,
		CMD_TICK = 2'd1,
		CMD_READ_RETURN = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Bus request kinds.
	typedef enum logic [1:0] {
		REQ_NONE = 2'd0,
		REQ_READ = 2'd1,
		REQ_WRITE = 2'd2
	} req_t;

	// Transfer phase.
	typedef enum logic {
		PHASE_READ = 1'b0,
		PHASE_WRITE = 1'b1
	} phase_t;

	// One input item.
	typedef struct packed {
		cmd_t command;
		logic [31:0] access_address;
		logic signed [31:0] write_value;
		logic [31:0] read_data;
	} item_t;

	// One result item.
	typedef struct packed {
		req_t bus_request;
		logic [31:0] bus_address;
		logic [31:0] bus_data;
		logic [2:0] bus_bytes;
		logic interrupt;
		logic busy_res;
	} result_t;

endpackage

>>> rtl/core/dce_in_stage.sv
`timescale 1ns / 1ps

module dce_in_stage (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dce_pkg::item_t in_item,
	output logic valid_s1,
	output dce_pkg::item_t item_s1,
	input logic advance
);

	// The stage takes a new beat when it is empty or its item moves on.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input register.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> rtl/core/dce_core.sv
`timescale 1ns / 1ps

module dce_core (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input dce_pkg::item_t item_s1,
	input logic [31:0] base_address,
	output dce_pkg::result_t result
);

	logic [31:0] source_pointer_q, source_pointer_d;
	logic [31:0] target_pointer_q, target_pointer_d;
	logic [31:0] remaining_count_q, remaining_count_d;
	logic running_q, running_d;
	dce_pkg::phase_t phase_q, phase_d;
	logic [31:0] held_word_q, held_word_d;
	logic [dce_pkg::PULSE_W-1:0] pulse_q, pulse_d;
	logic [31:0] offset;
	logic count_finishes;
	logic count_short;

	assign offset = item_s1.access_address - base_address;
	// Signed count of at most four ends the transfer on this write.
	assign count_finishes = remaining_count_q[31] || (remaining_count_q <= 32'd4);
	assign count_short = (remaining_count_q >= 32'd1) && (remaining_count_q <= 32'd3);

	// Next state and result of the item in the input register.
	always_comb begin
		source_pointer_d = source_pointer_q;
		target_pointer_d = target_pointer_q;
		remaining_count_d = remaining_count_q;
		running_d = running_q;
		phase_d = phase_q;
		held_word_d = held_word_q;
		pulse_d = pulse_q;
		result.bus_request = dce_pkg::REQ_NONE;
		result.bus_address = '0;
		result.bus_data = '0;
		result.bus_bytes = '0;

		unique case (item_s1.command)
			dce_pkg::CMD_REG_WRITE: begin
				if (offset == dce_pkg::OFF_SOURCE) begin
					source_pointer_d = item_s1.write_value;
				end else if (offset == dce_pkg::OFF_TARGET) begin
					target_pointer_d = item_s1.write_value;
				end else if (offset == dce_pkg::OFF_COUNT) begin
					remaining_count_d = item_s1.write_value;
				end else if (offset == dce_pkg::OFF_START) begin
					running_d = (item_s1.write_value > 32'sd0);
				end
			end
			dce_pkg::CMD_TICK: begin
				if (pulse_q != '0) begin
					pulse_d = pulse_q - 1'b1;
				end else if (running_q) begin
					if (phase_q == dce_pkg::PHASE_READ) begin
						result.bus_request = dce_pkg::REQ_READ;
						result.bus_address = source_pointer_q;
						result.bus_bytes = dce_pkg::WORD_BYTES;
						phase_d = dce_pkg::PHASE_WRITE;
					end else begin
						result.bus_request = dce_pkg::REQ_WRITE;
						result.bus_address = target_pointer_q;
						result.bus_data = held_word_q;
						result.bus_bytes = count_short ? remaining_count_q[2:0]
							: dce_pkg::WORD_BYTES;
						phase_d = dce_pkg::PHASE_READ;
						if (!count_finishes) begin
							source_pointer_d = source_pointer_q + dce_pkg::WORD_STEP;
							target_pointer_d = target_pointer_q + dce_pkg::WORD_STEP;
							remaining_count_d = remaining_count_q - dce_pkg::WORD_STEP;
						end else begin
							source_pointer_d = '0;
							target_pointer_d = '0;
							remaining_count_d = '0;
							running_d = 1'b0;
							pulse_d = dce_pkg::PULSE_W'(dce_pkg::IRQ_PULSE_TICKS);
						end
					end
				end
			end
			dce_pkg::CMD_READ_RETURN: begin
				held_word_d = item_s1.read_data;
			end
			dce_pkg::CMD_CLEAR: begin
				source_pointer_d = '0;
				target_pointer_d = '0;
				remaining_count_d = '0;
				running_d = 1'b0;
				phase_d = dce_pkg::PHASE_READ;
				pulse_d = '0;
			end
			default: begin
			end
		endcase

		result.interrupt = (pulse_d != '0);
		result.busy_res = running_d;
	end

	// Engine state, updated once per processed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_pointer_q <= '0;
			target_pointer_q <= '0;
			remaining_count_q <= '0;
			running_q <= 1'b0;
			phase_q <= dce_pkg::PHASE_READ;
			held_word_q <= '0;
			pulse_q <= '0;
		end else if (fire) begin
			source_pointer_q <= source_pointer_d;
			target_pointer_q <= target_pointer_d;
			remaining_count_q <= remaining_count_d;
			running_q <= running_d;
			phase_q <= phase_d;
			held_word_q <= held_word_d;
			pulse_q <= pulse_d;
		end
	end

endmodule

>>> rtl/core/dce_out_stage.sv
`timescale 1ns / 1ps

module dce_out_stage (
	input logic clk,
	input logic arst_n,
	input logic load,
	input dce_pkg::result_t result,
	output logic advance,
	output logic out_valid,
	input logic out_ready,
	output dce_pkg::result_t out_result
);

	logic valid_q;
	dce_pkg::result_t result_q;

	// A new result may enter when the register is empty or being drained.
	assign advance = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_result = result_q;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	// Payload of the result register.
	always_ff @(posedge clk) begin
		if (advance && load) begin
			result_q <= result;
		end
	end

endmodule

>>> rtl/core/dma_copy_engine_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  tuser: command; tdata: access_address, write_value, read_data
// m_*      out  m_tvalid/m_tready  tuser: bus_request; tdata: address, data, bytes, irq, busy
// APB      in   psel&penable       one register, base_address at offset 0
//
// Every input beat yields exactly one result beat, through the input register and then the result register.
// One beat is accepted per cycle while the output is not stalled; the engine state is registered per processed beat.
// A stalled output register holds its beat and back-pressures the input register.
// Reset is asynchronous and clears the engine state, the base address and all valids.

module dma_copy_engine_top (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// [31:0] access_address, [63:32] write_value, [95:64] read_data
	input logic [95:0] s_tdata,
	// [1:0] command
	input logic [1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// [31:0] bus_address, [63:32] bus_data, [66:64] bus_bytes, [67] interrupt,
	// [68] busy_res, [71:69] zero
	output logic [71:0] m_tdata,
	// [1:0] bus_request
	output logic [1:0] m_tuser,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [31:0] base_address_q;
	dce_pkg::item_t in_item;
	dce_pkg::item_t item_s1;
	logic valid_s1;
	logic advance;
	dce_pkg::result_t result;
	dce_pkg::result_t out_result;

	// Configuration register access.
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : base_address_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= '0;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			base_address_q <= pwdata;
		end
	end

	// Unpack the input beat.
	always_comb begin
		in_item.command = dce_pkg::cmd_t'(s_tuser);
		in_item.access_address = s_tdata[31:0];
		in_item.write_value = s_tdata[63:32];
		in_item.read_data = s_tdata[95:64];
	end

	dce_in_stage u_in_stage (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item(in_item),
		.valid_s1(valid_s1),
		.item_s1(item_s1),
		.advance(advance)
	);

	dce_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(valid_s1 && advance),
		.item_s1(item_s1),
		.base_address(base_address_q),
		.result(result)
	);

	dce_out_stage u_out_stage (
		.clk(clk),
		.arst_n(arst_n),
		.load(valid_s1),
		.result(result),
		.advance(advance),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_result(out_result)
	);

	// Pack the result beat.
	assign m_tuser = out_result.bus_request;
	assign m_tdata = {3'b000, out_result.busy_res, out_result.interrupt,
		out_result.bus_bytes, out_result.bus_data, out_result.bus_address};

endmodule
